// File: rtl/jsu_pkg.sv
package jsu_pkg;

   localparam int PhaseWidth  = 3;
   localparam int StatusWidth = 3;
   localparam int ByteWidth   = 8;
   localparam int MaxResults  = 4;
   localparam int IdxWidth    = $clog2(MaxResults);
   localparam int CpWidth     = 21;

   localparam logic [PhaseWidth-1:0] PH_PLAIN = 3'd0;
   localparam logic [PhaseWidth-1:0] PH_ESC   = 3'd1;
   localparam logic [PhaseWidth-1:0] PH_HEX1  = 3'd2;
   localparam logic [PhaseWidth-1:0] PH_SBS   = 3'd3;
   localparam logic [PhaseWidth-1:0] PH_SU    = 3'd4;
   localparam logic [PhaseWidth-1:0] PH_HEX2  = 3'd5;

   localparam logic [StatusWidth-1:0] ST_BYTE    = 3'd0;
   localparam logic [StatusWidth-1:0] ST_DONE    = 3'd1;
   localparam logic [StatusWidth-1:0] ST_NOQUOTE = 3'd2;
   localparam logic [StatusWidth-1:0] ST_BADHEX  = 3'd3;
   localparam logic [StatusWidth-1:0] ST_BADSUR  = 3'd4;
   localparam logic [StatusWidth-1:0] ST_BADESC  = 3'd5;
   localparam logic [StatusWidth-1:0] ST_CTRL    = 3'd6;

   localparam logic [7:0] CH_NUL    = 8'h00;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_B      = 8'h62;
   localparam logic [7:0] CH_F      = 8'h66;
   localparam logic [7:0] CH_N      = 8'h6E;
   localparam logic [7:0] CH_R      = 8'h72;
   localparam logic [7:0] CH_T      = 8'h74;
   localparam logic [7:0] CH_U      = 8'h75;

   localparam logic [15:0] HI_SUR_MIN = 16'hD800;
   localparam logic [15:0] HI_SUR_MAX = 16'hDBFF;
   localparam logic [15:0] LO_SUR_MIN = 16'hDC00;
   localparam logic [15:0] LO_SUR_MAX = 16'hDFFF;
   localparam logic [CpWidth-1:0] SUPP_BASE = 21'h10000;
   localparam logic [CpWidth-1:0] LIM_1B = 21'h7F;
   localparam logic [CpWidth-1:0] LIM_2B = 21'h7FF;
   localparam logic [CpWidth-1:0] LIM_3B = 21'hFFFF;

   typedef struct packed {
      logic                                has;
      logic [IdxWidth-1:0]                 last_idx;
      logic [StatusWidth-1:0]              status;
      logic [MaxResults-1:0][ByteWidth-1:0] bytes;
   } res_type;

   function automatic logic [4:0] hex_val(logic [7:0] b);
      logic [4:0] v;
      v = 5'd16;
      if (b >= 8'h30 && b <= 8'h39) v = 5'(b - 8'h30);
      else if (b >= 8'h41 && b <= 8'h46) v = 5'(b - 8'h41 + 8'd10);
      else if (b >= 8'h61 && b <= 8'h66) v = 5'(b - 8'h61 + 8'd10);
      return v;
   endfunction

   function automatic res_type one_byte(logic [7:0] b);
      res_type r;
      r = '0;
      r.has = 1'b1;
      r.status = ST_BYTE;
      r.bytes[0] = b;
      return r;
   endfunction

   function automatic res_type end_res(logic [StatusWidth-1:0] st);
      res_type r;
      r = '0;
      r.has = 1'b1;
      r.status = st;
      return r;
   endfunction

   function automatic res_type encode_cp(logic [CpWidth-1:0] u);
      res_type r;
      r = '0;
      r.has = 1'b1;
      r.status = ST_BYTE;
      if (u <= LIM_1B) begin
         r.last_idx = IdxWidth'(0);
         r.bytes[0] = u[7:0];
      end else if (u <= LIM_2B) begin
         r.last_idx = IdxWidth'(1);
         r.bytes[0] = {3'b110, u[10:6]};
         r.bytes[1] = {2'b10, u[5:0]};
      end else if (u <= LIM_3B) begin
         r.last_idx = IdxWidth'(2);
         r.bytes[0] = {4'b1110, u[15:12]};
         r.bytes[1] = {2'b10, u[11:6]};
         r.bytes[2] = {2'b10, u[5:0]};
      end else begin
         r.last_idx = IdxWidth'(3);
         r.bytes[0] = {5'b11110, u[20:18]};
         r.bytes[1] = {2'b10, u[17:12]};
         r.bytes[2] = {2'b10, u[11:6]};
         r.bytes[3] = {2'b10, u[5:0]};
      end
      return r;
   endfunction

endpackage

// File: rtl/json_string_unescape_utf8.sv
// JSON string body unescaper with UTF-8 output. Feed the bytes of a string body
// (opening quote already removed) one per req transaction; byte 0 marks the end
// of the source. Each byte yields zero to four rsp transactions: decoded bytes
// with status 0, or a single done/error transaction that ends the string, after
// which the next byte starts a new string. rsp_tlast marks the final transaction
// caused by one input byte. A byte is decoded combinationally between the input
// register and the result register, so the block takes one byte per cycle while
// each byte yields at most one result and rsp_tready is high; a \u escape holds
// the result register until the single result port has taken each UTF-8 byte.
module json_string_unescape_utf8 (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [7:0]                      req_tdata,  // [7:0] in_byte
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [7:0]                      rsp_tdata,  // [7:0] out_byte
   output logic [jsu_pkg::StatusWidth-1:0] rsp_tuser,  // [2:0] status
   output logic                            rsp_tlast
);
   import jsu_pkg::*;

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff, in_byte_in;
   logic       free;
   logic       move;
   logic       accept;
   res_type    res;

   assign move       = in_valid_ff && free;
   assign req_tready = !in_valid_ff || free;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      if (accept) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_tdata;
      end else if (move) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
      if (reset) in_valid_ff <= 1'b0;
      else       in_valid_ff <= in_valid_in;
   end

   jsu_decode u_decode (
      .clock   (clock),
      .reset   (reset),
      .fire    (move),
      .byte_in (in_byte_ff),
      .res     (res)
   );

   jsu_emit u_emit (
      .clock      (clock),
      .reset      (reset),
      .load       (move && res.has),
      .res        (res),
      .free       (free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// File: rtl/jsu_decode.sv
module jsu_decode (
   input  logic              clock,
   input  logic              reset,
   input  logic              fire,
   input  logic [7:0]        byte_in,
   output jsu_pkg::res_type  res
);
   import jsu_pkg::*;

   logic [PhaseWidth-1:0] phase_ff, phase_in;
   logic [1:0]            cnt_ff, cnt_in;
   logic [15:0]           acc_ff, acc_in;
   logic [9:0]            high_ff, high_in;
   logic [4:0]            dig;
   logic [15:0]           acc_new;

   assign dig     = hex_val(byte_in);
   assign acc_new = {acc_ff[11:0], dig[3:0]};

   always_comb begin
      phase_in = phase_ff;
      cnt_in   = cnt_ff;
      acc_in   = acc_ff;
      high_in  = high_ff;
      res      = '0;
      unique case (phase_ff) inside
         PH_ESC: begin
            phase_in = PH_PLAIN;
            case (byte_in) inside
               CH_QUOTE, CH_BSLASH, CH_SLASH: res = one_byte(byte_in);
               CH_B: res = one_byte(8'h08);
               CH_F: res = one_byte(8'h0C);
               CH_N: res = one_byte(8'h0A);
               CH_R: res = one_byte(8'h0D);
               CH_T: res = one_byte(8'h09);
               CH_U: begin
                  phase_in = PH_HEX1;
                  cnt_in   = 2'd0;
                  acc_in   = '0;
               end
               default: begin
                  res     = end_res(ST_BADESC);
                  cnt_in  = 2'd0;
                  acc_in  = '0;
                  high_in = '0;
               end
            endcase
         end
         PH_HEX1, PH_HEX2: begin
            if (dig[4]) begin
               res      = end_res(ST_BADHEX);
               phase_in = PH_PLAIN;
               cnt_in   = 2'd0;
               acc_in   = '0;
               high_in  = '0;
            end else if (cnt_ff != 2'd3) begin
               cnt_in = cnt_ff + 2'd1;
               acc_in = acc_new;
            end else begin
               cnt_in = 2'd0;
               acc_in = '0;
               if (phase_ff == PH_HEX1) begin
                  if (acc_new >= HI_SUR_MIN && acc_new <= HI_SUR_MAX) begin
                     high_in  = acc_new[9:0];
                     phase_in = PH_SBS;
                  end else begin
                     phase_in = PH_PLAIN;
                     res      = encode_cp({5'd0, acc_new});
                  end
               end else begin
                  phase_in = PH_PLAIN;
                  high_in  = '0;
                  if (acc_new < LO_SUR_MIN || acc_new > LO_SUR_MAX) begin
                     res = end_res(ST_BADSUR);
                  end else begin
                     res = encode_cp({1'b0, high_ff, acc_new[9:0]} + SUPP_BASE);
                  end
               end
            end
         end
         PH_SBS, PH_SU: begin
            if (byte_in != ((phase_ff == PH_SBS) ? CH_BSLASH : CH_U)) begin
               res      = end_res(ST_BADSUR);
               phase_in = PH_PLAIN;
               cnt_in   = 2'd0;
               acc_in   = '0;
               high_in  = '0;
            end else if (phase_ff == PH_SBS) begin
               phase_in = PH_SU;
            end else begin
               phase_in = PH_HEX2;
               cnt_in   = 2'd0;
               acc_in   = '0;
            end
         end
         default: begin
            phase_in = PH_PLAIN;
            if (byte_in == CH_BSLASH) begin
               phase_in = PH_ESC;
            end else if (byte_in >= CH_SPACE && byte_in != CH_QUOTE) begin
               res = one_byte(byte_in);
            end else begin
               if (byte_in == CH_QUOTE) res = end_res(ST_DONE);
               else if (byte_in == CH_NUL) res = end_res(ST_NOQUOTE);
               else res = end_res(ST_CTRL);
               cnt_in  = 2'd0;
               acc_in  = '0;
               high_in = '0;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_PLAIN;
         cnt_ff   <= 2'd0;
         acc_ff   <= '0;
         high_ff  <= '0;
      end else if (fire) begin
         phase_ff <= phase_in;
         cnt_ff   <= cnt_in;
         acc_ff   <= acc_in;
         high_ff  <= high_in;
      end
   end

endmodule

// File: rtl/jsu_emit.sv
module jsu_emit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            load,
   input  jsu_pkg::res_type                res,
   output logic                            free,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [7:0]                      rsp_tdata,
   output logic [jsu_pkg::StatusWidth-1:0] rsp_tuser,
   output logic                            rsp_tlast
);
   import jsu_pkg::*;

   res_type             bund_ff, bund_in;
   logic                valid_ff, valid_in;
   logic [IdxWidth-1:0] idx_ff, idx_in;
   logic                take;
   logic                at_last;

   assign at_last    = (idx_ff == bund_ff.last_idx);
   assign take       = valid_ff && rsp_tready;
   assign free       = !valid_ff || (rsp_tready && at_last);
   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = bund_ff.bytes[idx_ff];
   assign rsp_tuser  = bund_ff.status;
   assign rsp_tlast  = at_last;

   always_comb begin
      bund_in  = bund_ff;
      valid_in = valid_ff;
      idx_in   = idx_ff;
      if (load) begin
         bund_in  = res;
         valid_in = 1'b1;
         idx_in   = '0;
      end else if (take && at_last) begin
         valid_in = 1'b0;
      end else if (take) begin
         idx_in = idx_ff + IdxWidth'(1);
      end
   end

   always_ff @(posedge clock) begin
      bund_ff <= bund_in;
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

endmodule
